// File: rtl/slpe_pkg.sv
// Shared types and codes for the sorted list pool engine.
package slpe_pkg;

  localparam int VAL_W = 32;

  typedef logic signed [VAL_W-1:0] val_t;

  // Operation codes
  localparam logic [2:0] OP_INSERT   = 3'd0;
  localparam logic [2:0] OP_DEL_HEAD = 3'd1;
  localparam logic [2:0] OP_DEL_TAIL = 3'd2;
  localparam logic [2:0] OP_DEL_MID  = 3'd3;
  localparam logic [2:0] OP_DUMP     = 3'd4;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_MISS  = 2'd3;

  typedef struct packed {
    logic [2:0] op;
    val_t       value;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    val_t       item;
    logic       last;
  } res_t;

  // Command broadcast to every cell of the row
  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_CHECK,
    CMD_INSERT,
    CMD_POP_HEAD,
    CMD_DROP_LAST,
    CMD_DEL_GE,
    CMD_ROTATE
  } cell_cmd_e;

  typedef struct packed {
    cell_cmd_e cmd;
    val_t      key;
  } cell_ctrl_t;

endpackage

// File: rtl/sorted_list_pool_engine_core.sv
// Sorted list pool engine: a row of sorted cells with a command sequencer.
//
// The list holds up to POOL_SLOTS-1 signed 32-bit values in ascending order, kept in a row
// of cells that shift entries to their neighbors. A request is taken when start_i is high
// and busy_o is low. Insert and the three delete operations pass through the request edge, a
// check state in which every cell flags a match with the value, and an apply state in which
// the flags are combined and the row shifts; the single result shows on res_o, with
// res_strobe_o high, in the cycle after that, and a new request may be taken in that same
// cycle. A dump rotates the row one position a cycle and sends one entry a cycle out of the
// head cell, so it gives one result per entry; an empty list gives one result with status
// empty. Results appear for exactly one cycle, and the receiver cannot hold them off.
module sorted_list_pool_engine_core import slpe_pkg::*; #(
  parameter int unsigned POOL_SLOTS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  req_t req_i,
  output logic busy_o,
  output logic res_strobe_o,
  output res_t res_o
);

  localparam int unsigned NC    = POOL_SLOTS - 1;
  localparam int unsigned CNT_W = $clog2(POOL_SLOTS);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CHECK = 2'd1;
  localparam logic [1:0] S_APPLY = 2'd2;
  localparam logic [1:0] S_DUMP  = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [2:0]       op_q, op_d;
  val_t             key_q, key_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic             strobe_q, strobe_d;
  res_t             res_q, res_d;
  cell_ctrl_t       ctrl;

  val_t          cell_val [NC];
  logic [NC-1:0] cell_vld;
  logic [NC-1:0] cell_lt;
  logic [NC-1:0] cell_eq;
  logic [NC-1:0] cell_last;

  logic any_eq;
  logic tail_eq;

  // Row of cells
  for (genvar i = 0; i < NC; i++) begin : g_cell
    val_t left_val;
    logic left_vld;
    logic left_lt;
    val_t right_val;
    logic right_vld;

    if (i == 0) begin : g_first
      assign left_val = ctrl.key;
      assign left_vld = 1'b0;
      assign left_lt  = 1'b1;
    end else begin : g_mid_left
      assign left_val = cell_val[i-1];
      assign left_vld = cell_vld[i-1];
      assign left_lt  = cell_lt[i-1];
    end

    if (i == NC - 1) begin : g_end
      assign right_val = '0;
      assign right_vld = 1'b0;
    end else begin : g_mid_right
      assign right_val = cell_val[i+1];
      assign right_vld = cell_vld[i+1];
    end

    slpe_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .head_val_i  (cell_val[0]),
      .left_val_i  (left_val),
      .left_vld_i  (left_vld),
      .left_lt_i   (left_lt),
      .right_val_i (right_val),
      .right_vld_i (right_vld),
      .val_o       (cell_val[i]),
      .vld_o       (cell_vld[i]),
      .lt_o        (cell_lt[i]),
      .eq_o        (cell_eq[i]),
      .last_o      (cell_last[i])
    );
  end

  // Combine the registered match flags
  assign any_eq  = |cell_eq;
  assign tail_eq = |(cell_eq & cell_last);

  // Sequencer
  always_comb begin
    state_d  = state_q;
    op_d     = op_q;
    key_d    = key_q;
    cnt_d    = cnt_q;
    idx_d    = idx_q;
    strobe_d = 1'b0;
    res_d    = res_q;
    ctrl.cmd = CMD_HOLD;
    ctrl.key = key_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          op_d    = req_i.op;
          key_d   = req_i.value;
          idx_d   = '0;
          state_d = (req_i.op == OP_DUMP) ? S_DUMP : S_CHECK;
        end
      end
      S_CHECK: begin
        ctrl.cmd = CMD_CHECK;
        state_d  = S_APPLY;
      end
      S_APPLY: begin
        res_d.item = key_q;
        res_d.last = 1'b1;
        strobe_d   = 1'b1;
        state_d    = S_IDLE;
        res_d.status = ST_MISS;
        if (op_q == OP_INSERT) begin
          if (cell_vld[NC-1]) begin
            res_d.status = ST_FULL;
          end else begin
            res_d.status = ST_OK;
            ctrl.cmd     = CMD_INSERT;
            cnt_d        = cnt_q + CNT_W'(1);
          end
        end else if (op_q == OP_DEL_HEAD || op_q == OP_DEL_TAIL || op_q == OP_DEL_MID) begin
          priority if (!cell_vld[0]) begin
            res_d.status = ST_EMPTY;
          end else if (op_q == OP_DEL_HEAD && cell_eq[0]) begin
            res_d.status = ST_OK;
            ctrl.cmd     = CMD_POP_HEAD;
            cnt_d        = cnt_q - CNT_W'(1);
          end else if (op_q == OP_DEL_TAIL && tail_eq) begin
            res_d.status = ST_OK;
            ctrl.cmd     = CMD_DROP_LAST;
            cnt_d        = cnt_q - CNT_W'(1);
          end else if (op_q == OP_DEL_MID && any_eq && !cell_eq[0] && !tail_eq) begin
            // only an interior entry can match here
            res_d.status = ST_OK;
            ctrl.cmd     = CMD_DEL_GE;
            cnt_d        = cnt_q - CNT_W'(1);
          end else begin
            res_d.status = ST_MISS;
          end
        end
      end
      S_DUMP: begin
        strobe_d = 1'b1;
        if (!cell_vld[0]) begin
          res_d.status = ST_EMPTY;
          res_d.item   = '0;
          res_d.last   = 1'b1;
          state_d      = S_IDLE;
        end else begin
          // head entry out, row rotates one place
          ctrl.cmd     = CMD_ROTATE;
          res_d.status = ST_OK;
          res_d.item   = cell_val[0];
          res_d.last   = (idx_q == cnt_q - CNT_W'(1));
          idx_d        = idx_q + CNT_W'(1);
          if (idx_q == cnt_q - CNT_W'(1)) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      idx_q    <= '0;
      strobe_q <= 1'b0;
      op_q     <= OP_INSERT;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      idx_q    <= idx_d;
      strobe_q <= strobe_d;
      op_q     <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    res_q <= res_d;
  end

  assign busy_o       = (state_q != S_IDLE);
  assign res_strobe_o = strobe_q;
  assign res_o        = res_q;

`ifndef SYNTH
  // Occupied cells always form a prefix of the row
  a_vld_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((cell_vld >> 1) & ~cell_vld) == '0)
    else $error("occupied cells not contiguous");

  // Entry count tracks the occupied cells
  a_cnt_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(cell_vld) == int'(cnt_q))
    else $error("entry count out of step with cells");

  // A result only follows a working cycle
  a_strobe_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o |-> $past(state_q != S_IDLE))
    else $error("result without a request in flight");

  // A taken request makes the block busy
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("request taken but block not busy");
`endif

endmodule

// File: rtl/slpe_cell.sv
// One list cell: holds one entry and shifts it to or from its neighbors.
module slpe_cell import slpe_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  val_t       head_val_i,
  input  val_t       left_val_i,
  input  logic       left_vld_i,
  input  logic       left_lt_i,
  input  val_t       right_val_i,
  input  logic       right_vld_i,
  output val_t       val_o,
  output logic       vld_o,
  output logic       lt_o,
  output logic       eq_o,
  output logic       last_o
);

  val_t val_q, val_d;
  logic vld_q, vld_d;
  logic eq_q, eq_d;
  logic last_q, last_d;
  logic lt;
  logic is_last;

  // Local compare against the broadcast key, and the last-entry test
  assign lt      = vld_q && (val_q < ctrl_i.key);
  assign is_last = vld_q && !right_vld_i;

  // Next entry from the command and the neighbors
  always_comb begin
    val_d  = val_q;
    vld_d  = vld_q;
    eq_d   = eq_q;
    last_d = last_q;
    unique case (ctrl_i.cmd)
      CMD_HOLD: begin
      end
      CMD_CHECK: begin
        eq_d   = vld_q && (val_q == ctrl_i.key);
        last_d = is_last;
      end
      CMD_INSERT: begin
        if (!lt) begin
          if (left_lt_i) begin
            val_d = ctrl_i.key;
            vld_d = 1'b1;
          end else begin
            val_d = left_val_i;
            vld_d = left_vld_i;
          end
        end
      end
      CMD_POP_HEAD: begin
        val_d = right_val_i;
        vld_d = right_vld_i;
      end
      CMD_DROP_LAST: begin
        if (is_last) begin
          vld_d = 1'b0;
        end
      end
      CMD_DEL_GE: begin
        // entries at or past the match close the gap
        if (!lt) begin
          val_d = right_val_i;
          vld_d = right_vld_i;
        end
      end
      CMD_ROTATE: begin
        if (is_last) begin
          val_d = head_val_i;
        end else if (vld_q) begin
          val_d = right_val_i;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= 1'b0;
      eq_q   <= 1'b0;
      last_q <= 1'b0;
    end else begin
      vld_q  <= vld_d;
      eq_q   <= eq_d;
      last_q <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o  = val_q;
  assign vld_o  = vld_q;
  assign lt_o   = lt;
  assign eq_o   = eq_q;
  assign last_o = last_q;

endmodule

// File: bench/slpe_list_checker.sv
// Result checker for the sorted list pool engine: predicts each request's results and compares.
module slpe_list_checker import slpe_pkg::*; #(
  parameter int unsigned POOL_SLOTS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  req_t req_i,
  input  logic busy_i,
  input  logic res_strobe_i,
  input  res_t res_i,
  output int   err_cnt_o,
  output int   pending_o,
  output int   checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow of the list contents, ascending, head first
  val_t list_vals[$];
  // Results still owed by the engine, oldest first
  res_t due_results[$];

  int err_cnt = 0;
  int pending = 0;
  int checked = 0;

  assign err_cnt_o = err_cnt;
  assign pending_o = pending;
  assign checked_o = checked;

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    err_cnt++;
  endtask

  always @(posedge clk_i) begin : watch
    res_t want;
    res_t r;
    val_t v;
    int   n;
    int   i;
    if (rst_ni) begin
      // Compare a result against the oldest one owed
      if (res_strobe_i) begin
        checked++;
        if (due_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result status %0d item %0d last %0b",
                                    res_i.status, res_i.item, res_i.last));
        end else begin
          want = due_results.pop_front();
          if (res_i.status !== want.status)
            report_mismatch($sformatf("result %0d status %0d, want %0d",
                                      checked, res_i.status, want.status));
          if (res_i.item !== want.item)
            report_mismatch($sformatf("result %0d item %0d, want %0d",
                                      checked, res_i.item, want.item));
          if (res_i.last !== want.last)
            report_mismatch($sformatf("result %0d last %0b, want %0b",
                                      checked, res_i.last, want.last));
        end
      end

      // Apply an accepted request to the shadow list
      if (start_i && !busy_i) begin
        v = req_i.value;
        n = list_vals.size();
        if (req_i.op == OP_DUMP) begin
          if (n == 0) begin
            r.status = ST_EMPTY;
            r.item   = '0;
            r.last   = 1'b1;
            due_results.push_back(r);
          end else begin
            for (i = 0; i < n; i++) begin
              r.status = ST_OK;
              r.item   = list_vals[i];
              r.last   = (i == n - 1);
              due_results.push_back(r);
            end
          end
        end else begin
          r.status = ST_OK;
          r.item   = v;
          r.last   = 1'b1;
          case (req_i.op)
            OP_INSERT: begin
              if (n >= POOL_SLOTS - 1) begin
                r.status = ST_FULL;
              end else begin
                // new entry goes ahead of the first one that is not smaller
                i = 0;
                while (i < n && list_vals[i] < v) i++;
                list_vals.insert(i, v);
              end
            end
            OP_DEL_HEAD: begin
              if (n == 0) r.status = ST_EMPTY;
              else if (list_vals[0] != v) r.status = ST_MISS;
              else void'(list_vals.pop_front());
            end
            OP_DEL_TAIL: begin
              if (n == 0) r.status = ST_EMPTY;
              else if (list_vals[n-1] != v) r.status = ST_MISS;
              else void'(list_vals.pop_back());
            end
            OP_DEL_MID: begin
              if (n == 0) begin
                r.status = ST_EMPTY;
              end else if (list_vals[0] == v || list_vals[n-1] == v) begin
                r.status = ST_MISS;
              end else begin
                // only interior entries qualify; stop at the first not smaller
                i = 1;
                while (i < n - 1 && list_vals[i] < v) i++;
                if (i >= n - 1 || list_vals[i] != v) r.status = ST_MISS;
                else list_vals.delete(i);
              end
            end
            default: r.status = ST_MISS;
          endcase
          due_results.push_back(r);
        end
      end
      pending = due_results.size();
    end
  end

endmodule

// File: bench/sorted_list_pool_engine_core_test.sv
// Top-level testbench for the sorted list pool engine: stimulus, reset and verdict.
module sorted_list_pool_engine_core_test;
  import slpe_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned POOL_SLOTS = 16;
  localparam int RANDOM_ITEMS = 200;
  localparam int BURST_LEN = 20;
  localparam val_t VAL_MAX = val_t'(32'h7FFF_FFFF);
  localparam val_t VAL_MIN = val_t'(32'h8000_0000);

  logic clk_i   = 1'b0;
  logic rst_ni  = 1'b0;
  logic start_i = 1'b0;
  req_t req_i   = '0;
  logic busy_o;
  logic res_strobe_o;
  res_t res_o;

  int err_cnt;
  int pending;
  int checked;

  // Requests sent, by op code
  int   op_cnt[8];
  // Recently inserted values, reused so deletes hit often
  val_t recent_vals[$];
  // Burst with no idle gaps
  logic quiet = 1'b0;

  always #1 clk_i = ~clk_i;

  sorted_list_pool_engine_core #(.POOL_SLOTS(POOL_SLOTS)) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .req_i        (req_i),
    .busy_o       (busy_o),
    .res_strobe_o (res_strobe_o),
    .res_o        (res_o)
  );

  slpe_list_checker #(.POOL_SLOTS(POOL_SLOTS)) list_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .req_i        (req_i),
    .busy_i       (busy_o),
    .res_strobe_i (res_strobe_o),
    .res_i        (res_o),
    .err_cnt_o    (err_cnt),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  // Present one request after a random idle gap, which may be empty, and hold it until taken
  task automatic send_request(input logic [2:0] op, input val_t value);
    req_t rq;
    int   gap;
    rq.op    = op;
    rq.value = value;
    gap = quiet ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    req_i   <= rq;
    do @(posedge clk_i); while (busy_o);
    op_cnt[op]++;
    if (op == OP_INSERT) begin
      recent_vals.push_back(value);
      if (recent_vals.size() > 16) void'(recent_vals.pop_front());
    end
  endtask

  // Value for a random request: mostly a narrow range or a recent value
  function automatic val_t pick_value(input logic [2:0] op);
    val_t v;
    int   k;
    k = $urandom_range(0, 9);
    if (k == 0) begin
      v = $urandom;
    end else if (k == 1) begin
      v = $urandom_range(0, 1) ? VAL_MAX : VAL_MIN;
    end else if (k < 5 || recent_vals.size() == 0) begin
      v = val_t'($urandom_range(0, 8)) - 4;
    end else begin
      v = recent_vals[$urandom_range(0, recent_vals.size() - 1)];
      // ends are likeliest to match at the smallest or largest recent value
      if (op == OP_DEL_HEAD || op == OP_DEL_TAIL) begin
        foreach (recent_vals[i]) begin
          if (op == OP_DEL_HEAD && recent_vals[i] < v) v = recent_vals[i];
          if (op == OP_DEL_TAIL && recent_vals[i] > v) v = recent_vals[i];
        end
      end
    end
    return v;
  endfunction

  // Op for a random request, insert with the given percentage
  function automatic logic [2:0] pick_op(input int ins_pct);
    int r;
    if ($urandom_range(0, 99) < ins_pct) return OP_INSERT;
    r = $urandom_range(0, 19);
    if (r < 6) return OP_DEL_HEAD;
    if (r < 12) return OP_DEL_TAIL;
    if (r < 17) return OP_DEL_MID;
    if (r < 19) return OP_DUMP;
    return OP_DUMP + 3'($urandom_range(1, 3));
  endfunction

  initial begin : stimulus
    logic [2:0] op;
    int sent;
    int burst;
    int ins_pct;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Empty list: dump and every delete
    send_request(OP_DUMP, 32'sd7);
    send_request(OP_DEL_HEAD, 32'sd0);
    send_request(OP_DEL_TAIL, VAL_MAX);
    send_request(OP_DEL_MID, VAL_MIN);
    // Extremes, a duplicate and a negative value
    send_request(OP_INSERT, VAL_MAX);
    send_request(OP_INSERT, VAL_MIN);
    send_request(OP_INSERT, 32'sd0);
    send_request(OP_INSERT, 32'sd0);
    send_request(OP_INSERT, -32'sd1);
    send_request(OP_DUMP, 32'sd0);
    // Middle delete at the ends, of an absent value, then of an interior one
    send_request(OP_DEL_MID, VAL_MIN);
    send_request(OP_DEL_MID, VAL_MAX);
    send_request(OP_DEL_MID, 32'sd5);
    send_request(OP_DEL_MID, 32'sd0);
    // End deletes that miss, then hit
    send_request(OP_DEL_HEAD, 32'sd7);
    send_request(OP_DEL_HEAD, VAL_MIN);
    send_request(OP_DEL_TAIL, 32'sd3);
    send_request(OP_DEL_TAIL, VAL_MAX);
    // Unknown op codes
    send_request(OP_DUMP + 3'd1, 32'sd11);
    send_request(OP_DUMP + 3'd2, VAL_MIN);
    send_request(OP_DUMP + 3'd3, VAL_MAX);
    // Tail delete down to a single entry, then of that entry
    send_request(OP_DEL_TAIL, 32'sd0);
    send_request(OP_DEL_TAIL, -32'sd1);
    send_request(OP_DUMP, 32'sd0);

    // Random bursts: fill-heavy, drain-heavy or mixed, some with no gaps
    sent  = 0;
    burst = 0;
    while (sent < RANDOM_ITEMS) begin
      quiet = ($urandom_range(0, 3) == 0);
      case (burst == 0 ? 3 : $urandom_range(0, 2))
        0:       ins_pct = 70;
        1:       ins_pct = 20;
        2:       ins_pct = 45;
        default: ins_pct = 100;  // first burst runs the pool past full
      endcase
      for (int i = 0; i < BURST_LEN && sent < RANDOM_ITEMS; i++) begin
        op = pick_op(ins_pct);
        send_request(op, pick_value(op));
        sent++;
      end
      burst++;
    end
    start_i <= 1'b0;

    // Drain outstanding results, then watch for strays
    do @(posedge clk_i); while (pending != 0);
    repeat (40) @(posedge clk_i);

    $display("Covered %0d requests: %0d insert, %0d head delete, %0d tail delete, %0d middle delete,",
             op_cnt.sum(), op_cnt[OP_INSERT], op_cnt[OP_DEL_HEAD], op_cnt[OP_DEL_TAIL],
             op_cnt[OP_DEL_MID]);
    $display("%0d dump, %0d unknown op; %0d results checked, %0d mismatches",
             op_cnt[OP_DUMP], op_cnt.sum() - op_cnt[OP_INSERT] - op_cnt[OP_DEL_HEAD]
             - op_cnt[OP_DEL_TAIL] - op_cnt[OP_DEL_MID] - op_cnt[OP_DUMP], checked, err_cnt);
    if (err_cnt == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #400_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// File: files.f
rtl/slpe_pkg.sv
rtl/slpe_cell.sv
rtl/sorted_list_pool_engine_core.sv
bench/slpe_list_checker.sv
bench/sorted_list_pool_engine_core_test.sv
